// ----- src/cdfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfd_pkg
// Shared types and constants of the command-flagged datagram deframer.
// ----------------------------------------------------------------------------
package cdfd_pkg;

    localparam int unsigned CHAR_W = 9;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 5;

    localparam logic [POS_W-1:0] MIN_LEN    = 5'd3;
    localparam logic [POS_W-1:0] HEADER_POS = 5'd1;
    localparam logic [POS_W-1:0] FIRST_POS  = 5'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_CONTENT,
        PH_EMIT
    } phase_t;

    // Control that every cell of the store row sees in a cycle
    typedef struct packed {
        logic              wr_en;
        logic [POS_W-1:0]  wr_pos;
        logic [BYTE_W-1:0] wr_byte;
        logic              shift_en;
    } cell_ctrl_t;

endpackage

// ----- src/cdfd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfd_cell
// One byte slot of the store row: loads when addressed, else takes its
// neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module cdfd_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                       clk,
    input  cdfd_pkg::cell_ctrl_t       ctrl,
    input  logic [cdfd_pkg::BYTE_W-1:0] nbr_byte,
    output logic [cdfd_pkg::BYTE_W-1:0] cell_byte
);

    localparam logic [cdfd_pkg::POS_W-1:0] MY_POS = cdfd_pkg::POS_W'(IDX);

    logic [cdfd_pkg::BYTE_W-1:0] byte_reg;
    logic [cdfd_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.wr_en && (ctrl.wr_pos == MY_POS))
        begin
            byte_next = ctrl.wr_byte;
        end
        else if (ctrl.shift_en)
        begin
            // advance toward the head of the row
            byte_next = nbr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

// ----- src/cdfd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfd_ctrl
// Datagram sequencer: parses the length, addresses the store row and
// drains the finished datagram into the output register.
// ----------------------------------------------------------------------------
module cdfd_ctrl #(
    parameter int unsigned MAX_FRAME_BYTES = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cdfd_pkg::CHAR_W-1:0]  in_char,
    input  logic [cdfd_pkg::BYTE_W-1:0]  head_byte,
    output cdfd_pkg::cell_ctrl_t         cell_ctrl,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cdfd_pkg::BYTE_W-1:0]  out_byte,
    output logic [cdfd_pkg::POS_W-1:0]   out_pos,
    output logic [cdfd_pkg::POS_W-1:0]   out_len,
    output logic                         out_last
);

    localparam logic [cdfd_pkg::POS_W-1:0] MAX_POS = cdfd_pkg::POS_W'(MAX_FRAME_BYTES);

    cdfd_pkg::phase_t phase_reg;
    cdfd_pkg::phase_t phase_next;

    logic [cdfd_pkg::POS_W-1:0] wpos_reg, wpos_next;
    logic [cdfd_pkg::POS_W-1:0] exp_reg, exp_next;
    logic [cdfd_pkg::POS_W-1:0] rpos_reg, rpos_next;

    logic                        out_valid_reg, out_valid_next;
    logic [cdfd_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [cdfd_pkg::POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [cdfd_pkg::POS_W-1:0]  out_len_reg, out_len_next;
    logic                        out_last_reg, out_last_next;

    logic                        accept;
    logic                        is_cmd;
    logic [cdfd_pkg::POS_W-1:0]  hdr_len;
    logic [cdfd_pkg::POS_W-1:0]  wpos_inc;
    logic                        slot_free;
    logic                        store_ok;
    logic                        emit_last;

    assign accept    = in_valid && in_ready;
    assign is_cmd    = in_char[cdfd_pkg::CHAR_W-1];
    assign wpos_inc  = wpos_reg + 5'd1;
    assign store_ok  = (wpos_reg < MAX_POS);
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_last = (rpos_reg == (exp_reg - 5'd1));

    always_comb
    begin
        hdr_len = {1'b0, in_char[3:0]} + cdfd_pkg::MIN_LEN;
        if (hdr_len > MAX_POS)
        begin
            hdr_len = MAX_POS;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && is_cmd)
        begin
            phase_next = cdfd_pkg::PH_HEADER;
        end
        else
        begin
            case (phase_reg)
                cdfd_pkg::PH_HEADER:
                begin
                    if (accept)
                    begin
                        if (!store_ok)
                            phase_next = cdfd_pkg::PH_IDLE;
                        else if (wpos_inc > cdfd_pkg::FIRST_POS)
                            phase_next = (exp_reg > cdfd_pkg::MIN_LEN) ?
                                         cdfd_pkg::PH_CONTENT : cdfd_pkg::PH_EMIT;
                    end
                end
                cdfd_pkg::PH_CONTENT:
                begin
                    if (accept)
                    begin
                        if (!store_ok)
                            phase_next = cdfd_pkg::PH_IDLE;
                        else if (wpos_inc >= exp_reg)
                            phase_next = cdfd_pkg::PH_EMIT;
                    end
                end
                cdfd_pkg::PH_EMIT:
                begin
                    if (slot_free && emit_last)
                        phase_next = cdfd_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = cdfd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // datapath next values
    always_comb
    begin
        wpos_next      = wpos_reg;
        exp_next       = exp_reg;
        rpos_next      = rpos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        if (accept && is_cmd)
        begin
            wpos_next = cdfd_pkg::HEADER_POS;
            exp_next  = '0;
        end
        else if (accept && store_ok &&
                 ((phase_reg == cdfd_pkg::PH_HEADER) || (phase_reg == cdfd_pkg::PH_CONTENT)))
        begin
            wpos_next = wpos_inc;
            if ((phase_reg == cdfd_pkg::PH_HEADER) && (wpos_reg == cdfd_pkg::HEADER_POS))
            begin
                exp_next = hdr_len;
            end
        end

        if (accept && (phase_next == cdfd_pkg::PH_EMIT))
        begin
            rpos_next = '0;
        end

        if ((phase_reg == cdfd_pkg::PH_EMIT) && slot_free)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = head_byte;
            out_pos_next   = rpos_reg;
            out_len_next   = exp_reg;
            out_last_next  = emit_last;
            rpos_next      = rpos_reg + 5'd1;
        end
    end

    // outputs
    always_comb
    begin
        in_ready          = (phase_reg != cdfd_pkg::PH_EMIT);
        cell_ctrl.wr_en   = accept && (is_cmd ||
                            (store_ok && ((phase_reg == cdfd_pkg::PH_HEADER) ||
                                          (phase_reg == cdfd_pkg::PH_CONTENT))));
        cell_ctrl.wr_pos  = is_cmd ? '0 : wpos_reg;
        cell_ctrl.wr_byte = in_char[cdfd_pkg::BYTE_W-1:0];
        cell_ctrl.shift_en = (phase_reg == cdfd_pkg::PH_EMIT) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cdfd_pkg::PH_IDLE;
            wpos_reg      <= '0;
            exp_reg       <= '0;
            rpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            wpos_reg      <= wpos_next;
            exp_reg       <= exp_next;
            rpos_reg      <= rpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_pos   = out_pos_reg;
    assign out_len   = out_len_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- src/command_flagged_datagram_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_flagged_datagram_deframer
// Collects 9-bit link characters into datagrams and replays each finished
// datagram as a stream of byte beats.
// ----------------------------------------------------------------------------
// A character with bit 8 set opens a datagram and is kept as byte 0; the low
// nibble of the next byte plus 3 sets the datagram length (3 to 18, capped
// at MAX_FRAME_BYTES). When the last byte arrives, the datagram drains out
// of a row of byte cells, one beat per cycle toward the head cell while
// the output is not stalled, so a datagram of N bytes gives N output beats.
// Input is held off only during that drain. Data characters that arrive
// outside a datagram are dropped, and a command character mid-datagram
// drops the partial datagram and restarts.
// ----------------------------------------------------------------------------
module command_flagged_datagram_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 18
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] link_char, [15:9] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] frame_byte, [12:8] byte_position,
                                        // [17:13] frame_length, [23:18] zero
    output logic        m_axis_tlast    // last_byte
);

    cdfd_pkg::cell_ctrl_t        cell_ctrl;
    logic [cdfd_pkg::BYTE_W-1:0] cell_q [MAX_FRAME_BYTES];
    logic [cdfd_pkg::BYTE_W-1:0] out_byte;
    logic [cdfd_pkg::POS_W-1:0]  out_pos;
    logic [cdfd_pkg::POS_W-1:0]  out_len;

    cdfd_ctrl #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata[cdfd_pkg::CHAR_W-1:0]),
        .head_byte (cell_q[0]),
        .cell_ctrl (cell_ctrl),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (out_byte),
        .out_pos   (out_pos),
        .out_len   (out_len),
        .out_last  (m_axis_tlast)
    );

    // Row of byte cells; each shifts toward cell 0 while draining
    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAME_BYTES; gi++)
        begin : g_cell
            logic [cdfd_pkg::BYTE_W-1:0] nbr;
            if (gi == MAX_FRAME_BYTES - 1)
            begin : g_tail
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_q[gi+1];
            end

            cdfd_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .nbr_byte  (nbr),
                .cell_byte (cell_q[gi])
            );
        end
    endgenerate

    assign m_axis_tdata = {6'd0, out_len, out_pos, out_byte};

endmodule
